>>> rtl/julia_set_escape_time_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Julia set escape-time block
// Each use expands to one labeled concurrent assertion, clocked on the rising
// edge and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef JULIA_SET_ESCAPE_TIME_MACROS_SVH
`define JULIA_SET_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define JSET_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define JSET_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jset_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jset_pkg
// Shared types and constants of the Julia set escape-time block: register
// map, register widths, reset values and queue depth.
// ----------------------------------------------------------------------------
package jset_pkg;

  // Register file geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // Fixed field widths
  localparam int ITER_W   = 16;
  localparam int CNT_W    = ITER_W + 1;
  localparam int STEP_W   = 28;
  localparam int C_W      = 30;
  localparam int REG_FRAC = 28;

  // Start-point queue between front end and iterator
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITERATIONS = 3'd0,
    REG_X_STEP         = 3'd1,
    REG_Y_STEP         = 3'd2,
    REG_C_REAL         = 3'd3,
    REG_C_IMAG         = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ITER_W-1:0]     max_iterations;
    logic [STEP_W-1:0]     x_step;
    logic [STEP_W-1:0]     y_step;
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
  } cfg_t;

  // Defaults: 1000 x 1000 grid, c = -0.7 + 0.26i
  localparam cfg_t CFG_RESET = '{
    max_iterations: 16'd1000,
    x_step:         28'd805306,
    y_step:         28'd536871,
    c_real:         -30'sd187904819,
    c_imag:         30'sd69793219
  };

endpackage

>>> rtl/jset_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia set stream interfaces
// Valid/ready channels for pixel indices, start points and iteration counts.
// ----------------------------------------------------------------------------

// Pixel grid indices
interface jset_pix_if #(
  parameter int IDX_W = 12
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] x_index;
  logic [IDX_W-1:0] y_index;

  modport source (output valid, output x_index, output y_index, input ready);
  modport sink   (input valid, input x_index, input y_index, output ready);
endinterface

// Complex start point in signed fixed point
interface jset_pt_if #(
  parameter int ZW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [ZW-1:0] zx;
  logic signed [ZW-1:0] zy;

  modport source (output valid, output zx, output zy, input ready);
  modport sink   (input valid, input zx, input zy, output ready);
endinterface

// Escape-time result
interface jset_cnt_if;
  logic                       valid;
  logic                       ready;
  logic [jset_pkg::CNT_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

>>> rtl/jset_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jset_front
// Accepts pixel indices, scales them by the grid steps and forms the
// saturated start point z0 = (-1.5 + x_step*x, -1.0 + y_step*y).
// ----------------------------------------------------------------------------
module jset_front #(
  parameter int IDX_W     = 12,
  parameter int FRAC_BITS = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  jset_pkg::cfg_t   cfg,
  jset_pix_if.sink         pixel,
  jset_pt_if.source        pt
);

  localparam int ZW     = FRAC_BITS + 4;
  localparam int PROD_W = jset_pkg::STEP_W + IDX_W;
  localparam int UP     = (FRAC_BITS >= jset_pkg::REG_FRAC) ? FRAC_BITS - jset_pkg::REG_FRAC : 0;
  localparam int DN     = (FRAC_BITS <  jset_pkg::REG_FRAC) ? jset_pkg::REG_FRAC - FRAC_BITS : 0;
  localparam int SC_W   = PROD_W + UP;
  localparam int DW     = ((SC_W > ZW) ? SC_W : ZW) + 2;

  localparam logic signed [DW-1:0] OFF_X  = DW'(64'sd3 <<< (FRAC_BITS - 1));
  localparam logic signed [DW-1:0] OFF_Y  = DW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DW-1:0] SAT_HI = DW'((64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1);
  localparam logic signed [DW-1:0] SAT_LO = DW'(-(64'sd1 <<< (FRAC_BITS + 3)));

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic              s1_valid;

  // Bring an unsigned Q12.28 product (IDX_W = 12) to Q4.F, remove the offset, clamp to the Q4.F range
  function automatic logic signed [ZW-1:0] to_start(input logic [PROD_W-1:0] p,
                                                     input logic signed [DW-1:0] off);
    logic [SC_W-1:0]       sc;
    logic signed [DW-1:0]  d;
    sc = (SC_W'(p) << UP) >> DN;
    d  = signed'(DW'(sc)) - off;
    if (d > SAT_HI) begin
      d = SAT_HI;
    end else if (d < SAT_LO) begin
      d = SAT_LO;
    end
    return ZW'(d);
  endfunction

  // Advance the product stage when it is empty or its point moves on
  assign pixel.ready = !s1_valid || pt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
    if (pixel.valid && pixel.ready) begin
      prod_x <= PROD_W'(cfg.x_step) * PROD_W'(pixel.x_index);
      prod_y <= PROD_W'(cfg.y_step) * PROD_W'(pixel.y_index);
    end
  end

  // Offer the start point to the queue
  assign pt.valid = s1_valid;
  assign pt.zx    = to_start(prod_x, OFF_X);
  assign pt.zy    = to_start(prod_y, OFF_Y);

endmodule

>>> rtl/jset_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jset_queue
// Short FIFO of start points that decouples the front end from the iterator.
// ----------------------------------------------------------------------------
module jset_queue #(
  parameter int ZW = 32
) (
  input  logic      clk,
  input  logic      rst,
  jset_pt_if.sink   push,
  jset_pt_if.source pop
);

  localparam int DEPTH = jset_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  typedef struct packed {
    logic signed [ZW-1:0] zx;
    logic signed [ZW-1:0] zy;
  } entry_t;

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push.ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.zx     = mem[head].zx;
  assign pop.zy     = mem[head].zy;

  assign do_push = push.valid && push.ready;
  assign do_pop  = pop.valid && pop.ready;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  // Store incoming points
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= '{zx: push.zx, zy: push.zy};
    end
  end

endmodule

>>> rtl/jset_iter.sv
`timescale 1ns / 1ps
`include "julia_set_escape_time_macros.svh"
// ----------------------------------------------------------------------------
// jset_iter
// Iterates z = z*z + c on one start point until |z|^2 reaches 4 or the count
// passes the bound, then holds the count in the result register.
// ----------------------------------------------------------------------------
module jset_iter #(
  parameter int FRAC_BITS = 28
) (
  input  logic           clk,
  input  logic           rst,
  input  jset_pkg::cfg_t cfg,
  jset_pt_if.sink        pt,
  jset_cnt_if.source     result
);

  localparam int ZW    = FRAC_BITS + 4;
  localparam int PW    = 2 * ZW;
  localparam int CNT_W = jset_pkg::CNT_W;
  localparam int UP    = (FRAC_BITS >= jset_pkg::REG_FRAC) ? FRAC_BITS - jset_pkg::REG_FRAC : 0;
  localparam int DN    = (FRAC_BITS <  jset_pkg::REG_FRAC) ? jset_pkg::REG_FRAC - FRAC_BITS : 0;
  localparam int CW    = jset_pkg::C_W + UP;

  localparam logic [PW-1:0]        ESC_LIM = PW'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [ZW-1:0] Z_LIM   = ZW'(64'sd6 <<< FRAC_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_TEST
  } state_t;

  state_t               state;
  logic signed [ZW-1:0] zx;
  logic signed [ZW-1:0] zy;
  logic [CNT_W-1:0]     itr;
  logic signed [PW-1:0] xx;
  logic signed [PW-1:0] yy;
  logic signed [PW-1:0] xy;
  logic                 out_valid;
  logic [CNT_W-1:0]     out_count;

  logic signed [CW-1:0] cr_sc;
  logic signed [CW-1:0] ci_sc;
  logic signed [ZW-1:0] cr;
  logic signed [ZW-1:0] ci;
  logic [PW-1:0]        mag_sum;
  logic signed [PW-1:0] re_full;
  logic signed [ZW-1:0] zx_next;
  logic signed [ZW-1:0] zy_next;
  logic                 escaped;
  logic                 done;
  logic                 res_load;

  // Bring c from Q2.28 to Q4.F, rounding toward minus infinity
  assign cr_sc = (CW'(cfg.c_real) <<< UP) >>> DN;
  assign ci_sc = (CW'(cfg.c_imag) <<< UP) >>> DN;
  assign cr    = ZW'(cr_sc);
  assign ci    = ZW'(ci_sc);

  // Escape test on the exact squares, next point from floored products
  always_comb begin
    mag_sum = unsigned'(xx) + unsigned'(yy);
    escaped = (mag_sum >= ESC_LIM);
    done    = escaped || (itr > CNT_W'(cfg.max_iterations));
    re_full = xx - yy;
    zx_next = ZW'(re_full >>> FRAC_BITS) + cr;
    zy_next = ZW'(xy >>> (FRAC_BITS - 1)) + ci;
  end

  assign res_load = (state == ST_TEST) && done && (!out_valid || result.ready);
  assign pt.ready = (state == ST_IDLE);

  // Sequence the iteration and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
        out_count <= itr;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pt.valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (!done) begin
            state <= ST_MUL;
          end else if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Point, count and product registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pt.valid) begin
      zx  <= pt.zx;
      zy  <= pt.zy;
      itr <= '0;
    end
    if (state == ST_MUL) begin
      xx <= PW'(zx) * PW'(zx);
      yy <= PW'(zy) * PW'(zy);
      xy <= PW'(zx) * PW'(zy);
    end
    if (state == ST_TEST && !done) begin
      zx  <= zx_next;
      zy  <= zy_next;
      itr <= itr + CNT_W'(1);
    end
  end

  assign result.valid           = out_valid;
  assign result.iteration_count = out_count;

  `JSET_ASSERT_NXT(a_pop_starts, clk, rst, pt.valid && pt.ready, state == ST_MUL && itr == '0, "popped point did not start at count zero")
  `JSET_ASSERT_IMP(a_no_overwrite, clk, rst, res_load, !out_valid || result.ready, "result register overwritten")
  `JSET_ASSERT_IMP(a_count_bound, clk, rst, res_load, itr <= CNT_W'(cfg.max_iterations) + CNT_W'(1), "count beyond bound plus one")
  `JSET_ASSERT_IMP(a_z_range, clk, rst, state == ST_MUL && itr != '0, zx <= Z_LIM && zx >= -Z_LIM && zy <= Z_LIM && zy >= -Z_LIM, "iterated point out of range")

endmodule

>>> rtl/julia_set_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_set_escape_time
// Per-pixel Julia set escape-time engine with a writable register file.
// ----------------------------------------------------------------------------
// Each pixel (x_index, y_index) yields one iteration_count. The front end
// takes one pixel per cycle unless the queue is full, and its start point
// is ready in the cycle after; up to four start points wait in a queue.
// The iterator handles one pixel at a time: it takes the point while idle,
// then loops a multiply state (two squares, cross product) and a test state
// (escape test and update). The result sits in an output register until
// taken while the iterator already starts the next point. Registers
// (max_iterations, x_step, y_step, c_real, c_imag) are written through
// cfg_write/cfg_index/cfg_data; the user must do so only while the block is
// idle (not enforced here). Reset sets a 1000 x 1000 grid, c = -0.7 + 0.26i.
// ----------------------------------------------------------------------------
module julia_set_escape_time #(
  parameter int MAX_GRID  = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [jset_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jset_pkg::CFG_DATA_W-1:0] cfg_data,
  jset_pix_if.sink                        pixel,
  jset_cnt_if.source                      result
);

  localparam int IDX_W = $clog2(MAX_GRID);
  localparam int ZW    = FRAC_BITS + 4;

  jset_pkg::cfg_t cfg;

  jset_pt_if #(.ZW(ZW)) front_pt ();
  jset_pt_if #(.ZW(ZW)) back_pt ();

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= jset_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (jset_pkg::reg_idx_t'(cfg_index))
        jset_pkg::REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[jset_pkg::ITER_W-1:0];
        jset_pkg::REG_X_STEP:         cfg.x_step <= cfg_data[jset_pkg::STEP_W-1:0];
        jset_pkg::REG_Y_STEP:         cfg.y_step <= cfg_data[jset_pkg::STEP_W-1:0];
        jset_pkg::REG_C_REAL:         cfg.c_real <= signed'(cfg_data[jset_pkg::C_W-1:0]);
        jset_pkg::REG_C_IMAG:         cfg.c_imag <= signed'(cfg_data[jset_pkg::C_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  jset_front #(
    .IDX_W     (IDX_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .pixel (pixel),
    .pt    (front_pt)
  );

  jset_queue #(
    .ZW (ZW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_pt),
    .pop  (back_pt)
  );

  jset_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pt     (back_pt),
    .result (result)
  );

endmodule
